### design/fixed_timestep_accumulator_unit_macros.svh
// Assertion shorthands for the fixed timestep accumulator.
// Both expect clk and rst_n to be visible where they are used.
`ifndef FIXED_TIMESTEP_ACCUMULATOR_UNIT_MACROS_SVH
`define FIXED_TIMESTEP_ACCUMULATOR_UNIT_MACROS_SVH

// Same-cycle implication.
`define FTSA_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fixed timestep accumulator check failed");

// Next-cycle implication.
`define FTSA_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fixed timestep accumulator check failed");

`endif

### design/ftsacc_pkg.sv
package ftsacc_pkg;

    // field widths
    localparam int unsigned FRAME_TIME_W = 32;
    localparam int unsigned STEP_LEN_W   = 21;
    localparam int unsigned MAX_FT_W     = 23;
    localparam int unsigned MAX_STEPS_W  = 7;
    localparam int unsigned SCALE_W      = 16;
    localparam int unsigned DROPPED_W    = 24;
    localparam int unsigned FRAC_W       = 16;
    localparam int unsigned TOTAL_W      = 48;
    localparam int unsigned FRAME_NUM_W  = 32;
    localparam int unsigned SIM_TIME_W   = 56;

    // datapath widths
    localparam int unsigned BANK_W  = 40;
    localparam int unsigned PROD_W  = MAX_FT_W + SCALE_W;
    localparam int unsigned STEP_W  = STEP_LEN_W + 8;
    localparam int unsigned QUO_W   = BANK_W + FRAC_W;
    localparam int unsigned ADV_W   = MAX_STEPS_W + STEP_LEN_W;

    // long division: integer quotient bits, then fraction bits
    localparam int unsigned DIV_ITERS = QUO_W;
    localparam int unsigned DIV_CNT_W = $clog2(DIV_ITERS);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST  = DIV_CNT_W'(DIV_ITERS - 1);
    localparam logic [DIV_CNT_W-1:0] BANK_SNAP = DIV_CNT_W'(BANK_W);

    localparam logic [STEP_LEN_W-1:0] STEP_FLOOR = STEP_LEN_W'(105);
    localparam int unsigned CAP_LIMIT_DEF = 64;

    // configuration port
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = MAX_FT_W;

    localparam logic [CFG_IDX_W-1:0] CFG_STEP_LENGTH    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_FRAME_TIME = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_STEPS      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_SCALE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PAUSED         = 3'd4;

    localparam logic [STEP_LEN_W-1:0]  STEP_LENGTH_RST    = STEP_LEN_W'(17476);
    localparam logic [MAX_FT_W-1:0]    MAX_FRAME_TIME_RST = MAX_FT_W'(262144);
    localparam logic [MAX_STEPS_W-1:0] MAX_STEPS_RST      = MAX_STEPS_W'(8);
    localparam logic [SCALE_W-1:0]     TIME_SCALE_RST     = SCALE_W'(256);

    // controller to datapath
    typedef struct packed {
        logic load;     // latch clamped frame time
        logic mul;      // frame time times scale
        logic add;      // bank update, divider start
        logic iter;     // one restoring division step
        logic bank_wr;  // integer part done, remainder is the new bank
        logic tally;    // steps run and dropped
        logic scale;    // simulated time advance
        logic finish;   // totals and result register
    } ftsacc_cmd_t;

endpackage

### design/ftsacc_if.sv
interface ftsacc_frame_if import ftsacc_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [FRAME_TIME_W-1:0] frame_time;

    modport source (output valid, output frame_time, input ready);
    modport sink   (input valid, input frame_time, output ready);
endinterface

interface ftsacc_result_if import ftsacc_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [MAX_STEPS_W-1:0] steps_run;
    logic [DROPPED_W-1:0]   steps_dropped;
    logic [FRAC_W-1:0]      blend_fraction;
    logic [TOTAL_W-1:0]     total_steps;
    logic [TOTAL_W-1:0]     total_dropped;
    logic [FRAME_NUM_W-1:0] frame_number;
    logic [SIM_TIME_W-1:0]  simulated_time;

    modport source (output valid, output steps_run, output steps_dropped,
                    output blend_fraction, output total_steps, output total_dropped,
                    output frame_number, output simulated_time, input ready);
    modport sink   (input valid, input steps_run, input steps_dropped,
                    input blend_fraction, input total_steps, input total_dropped,
                    input frame_number, input simulated_time, output ready);
endinterface

### design/ftsacc_ctrl.sv
module ftsacc_ctrl import ftsacc_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    output logic        out_valid,
    input  logic        out_ready,
    output ftsacc_cmd_t cmd
);

    typedef enum logic [2:0] {
        IDLE,
        MUL,
        ADD,
        DIV,
        TALLY,
        SCALE,
        DONE
    } state_t;

    state_t               state_reg, state_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 finish;

    // result register free, or emptied in this cycle
    assign finish = (state_reg == DONE) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            IDLE:
            begin
                if (in_valid)
                begin
                    state_next = MUL;
                end
            end
            MUL:   state_next = ADD;
            ADD:
            begin
                state_next = DIV;
                cnt_next   = '0;
            end
            DIV:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST)
                begin
                    state_next = TALLY;
                end
            end
            TALLY: state_next = SCALE;
            SCALE: state_next = DONE;
            DONE:
            begin
                if (finish)
                begin
                    state_next = IDLE;
                end
            end
            default: state_next = IDLE;
        endcase

        out_valid_next = out_valid_reg;
        if (finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd         = '0;
        cmd.load    = (state_reg == IDLE) && in_valid;
        cmd.mul     = (state_reg == MUL);
        cmd.add     = (state_reg == ADD);
        cmd.iter    = (state_reg == DIV);
        cmd.bank_wr = (state_reg == DIV) && (cnt_reg == BANK_SNAP);
        cmd.tally   = (state_reg == TALLY);
        cmd.scale   = (state_reg == SCALE);
        cmd.finish  = finish;
    end

endmodule

### design/ftsacc_dp.sv
module ftsacc_dp import ftsacc_pkg::*; #(
    parameter int unsigned STEP_CAP_LIMIT = CAP_LIMIT_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    input  logic [FRAME_TIME_W-1:0] frame_time,
    input  ftsacc_cmd_t             cmd,
    output logic [MAX_STEPS_W-1:0]  steps_run,
    output logic [DROPPED_W-1:0]    steps_dropped,
    output logic [FRAC_W-1:0]       blend_fraction,
    output logic [TOTAL_W-1:0]      total_steps,
    output logic [TOTAL_W-1:0]      total_dropped,
    output logic [FRAME_NUM_W-1:0]  frame_number,
    output logic [SIM_TIME_W-1:0]   simulated_time
);

    localparam logic [MAX_STEPS_W-1:0] CAP_LIM = MAX_STEPS_W'(STEP_CAP_LIMIT);

    // configuration
    logic [STEP_LEN_W-1:0]  step_length_reg;
    logic [MAX_FT_W-1:0]    max_frame_time_reg;
    logic [MAX_STEPS_W-1:0] max_steps_reg;
    logic [SCALE_W-1:0]     time_scale_reg;
    logic                   paused_reg;

    // state
    logic [BANK_W-1:0]      bank_reg;
    logic [TOTAL_W-1:0]     step_total_reg;
    logic [TOTAL_W-1:0]     drop_total_reg;
    logic [FRAME_NUM_W-1:0] frame_total_reg;
    logic [SIM_TIME_W-1:0]  sim_clock_reg;

    // working registers
    logic [MAX_FT_W-1:0]    ft_reg;
    logic [PROD_W-1:0]      prod_reg;
    logic [QUO_W-1:0]       quo_reg;
    logic [STEP_W-1:0]      rem_reg;
    logic [MAX_STEPS_W-1:0] run_reg;
    logic [DROPPED_W-1:0]   drop_reg;
    logic [BANK_W-1:0]      drop_all_reg;
    logic [ADV_W-1:0]       adv_reg;
    logic [MAX_STEPS_W-1:0] run_out_reg;
    logic [DROPPED_W-1:0]   drop_out_reg;
    logic [FRAC_W-1:0]      frac_out_reg;

    logic [STEP_LEN_W-1:0]  len;
    logic [STEP_W-1:0]      step;
    logic                   frozen;
    logic [MAX_FT_W-1:0]    ft_clamped;
    logic [MAX_STEPS_W-1:0] cap;
    logic [BANK_W-1:0]      bank_sum;
    logic [STEP_W:0]        trial;
    logic                   fits;
    logic [STEP_W-1:0]      rem_next;
    logic [BANK_W-1:0]      whole;
    logic [BANK_W-1:0]      surplus;
    logic [MAX_STEPS_W-1:0] run_next;
    logic [DROPPED_W-1:0]   drop_next;
    logic [BANK_W-1:0]      drop_all_next;

    always_comb
    begin
        len        = (step_length_reg < STEP_FLOOR) ? STEP_FLOOR : step_length_reg;
        step       = {len, 8'b0};
        frozen     = paused_reg || (time_scale_reg == '0);
        ft_clamped = (frame_time > FRAME_TIME_W'(max_frame_time_reg))
                     ? max_frame_time_reg : frame_time[MAX_FT_W-1:0];
        cap        = (max_steps_reg > CAP_LIM) ? CAP_LIM : max_steps_reg;
        bank_sum   = frozen ? bank_reg : bank_reg + BANK_W'(prod_reg);

        // restoring division, one quotient bit per step
        trial    = {rem_reg, quo_reg[QUO_W-1]};
        fits     = (trial >= {1'b0, step});
        rem_next = fits ? STEP_W'(trial - {1'b0, step}) : trial[STEP_W-1:0];

        whole    = quo_reg[QUO_W-1:FRAC_W];
        surplus  = whole - BANK_W'(cap);
        run_next = (whole < BANK_W'(cap)) ? whole[MAX_STEPS_W-1:0] : cap;
        // the running total takes the full surplus, the result field saturates
        if (whole <= BANK_W'(cap))
        begin
            drop_all_next = '0;
            drop_next     = '0;
        end
        else if (surplus > BANK_W'({DROPPED_W{1'b1}}))
        begin
            drop_all_next = surplus;
            drop_next     = '1;
        end
        else
        begin
            drop_all_next = surplus;
            drop_next     = surplus[DROPPED_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_length_reg    <= STEP_LENGTH_RST;
            max_frame_time_reg <= MAX_FRAME_TIME_RST;
            max_steps_reg      <= MAX_STEPS_RST;
            time_scale_reg     <= TIME_SCALE_RST;
            paused_reg         <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_STEP_LENGTH:    step_length_reg    <= cfg_data[STEP_LEN_W-1:0];
                CFG_MAX_FRAME_TIME: max_frame_time_reg <= cfg_data[MAX_FT_W-1:0];
                CFG_MAX_STEPS:      max_steps_reg      <= cfg_data[MAX_STEPS_W-1:0];
                CFG_TIME_SCALE:     time_scale_reg     <= cfg_data[SCALE_W-1:0];
                CFG_PAUSED:         paused_reg         <= cfg_data[0];
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank_reg        <= '0;
            step_total_reg  <= '0;
            drop_total_reg  <= '0;
            frame_total_reg <= '0;
            sim_clock_reg   <= '0;
        end
        else
        begin
            if (cmd.add)
            begin
                bank_reg <= bank_sum;
            end
            else if (cmd.bank_wr)
            begin
                bank_reg <= BANK_W'(rem_reg);
            end
            if (cmd.finish)
            begin
                step_total_reg  <= step_total_reg + TOTAL_W'(run_reg);
                drop_total_reg  <= drop_total_reg + TOTAL_W'(drop_all_reg);
                frame_total_reg <= frame_total_reg + 1'b1;
                sim_clock_reg   <= sim_clock_reg + SIM_TIME_W'(adv_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ft_reg <= ft_clamped;
        end
        if (cmd.mul)
        begin
            prod_reg <= PROD_W'(ft_reg) * PROD_W'(time_scale_reg);
        end
        if (cmd.add)
        begin
            quo_reg <= {bank_sum, {FRAC_W{1'b0}}};
            rem_reg <= '0;
        end
        else if (cmd.iter)
        begin
            quo_reg <= {quo_reg[QUO_W-2:0], fits};
            rem_reg <= rem_next;
        end
        if (cmd.tally)
        begin
            run_reg      <= run_next;
            drop_reg     <= drop_next;
            drop_all_reg <= drop_all_next;
        end
        if (cmd.scale)
        begin
            adv_reg <= ADV_W'(run_reg) * ADV_W'(len);
        end
        if (cmd.finish)
        begin
            run_out_reg  <= run_reg;
            drop_out_reg <= drop_reg;
            frac_out_reg <= frozen ? '0 : quo_reg[FRAC_W-1:0];
        end
    end

    assign steps_run      = run_out_reg;
    assign steps_dropped  = drop_out_reg;
    assign blend_fraction = frac_out_reg;
    assign total_steps    = step_total_reg;
    assign total_dropped  = drop_total_reg;
    assign frame_number   = frame_total_reg;
    assign simulated_time = sim_clock_reg;

endmodule

### design/fixed_timestep_accumulator_unit.sv
// Channel  | Direction | Handshake     | Payload
// frame    | in        | valid / ready | frame_time
// result   | out       | valid / ready | steps_run .. simulated_time
// cfg      | in        | cfg_we        | cfg_index, cfg_data
//
// A request runs from acceptance to result as multiply, bank add,
// 56 restoring divide steps (40 integer, 16 fraction), tally, scale and finish.
// The divider is iterative; one request is in flight at a time.
// A finished result waits in the output register while the next request runs;
// the block holds in its last cycle only if that register is still full.
// Reset clears the bank, all totals and loads the register defaults.
`include "fixed_timestep_accumulator_unit_macros.svh"

module fixed_timestep_accumulator_unit import ftsacc_pkg::*; #(
    parameter int unsigned STEP_CAP_LIMIT = CAP_LIMIT_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    ftsacc_frame_if.sink          frame,
    ftsacc_result_if.source       result
);

    ftsacc_cmd_t cmd;

    ftsacc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (frame.valid),
        .in_ready  (frame.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .cmd       (cmd)
    );

    ftsacc_dp #(
        .STEP_CAP_LIMIT (STEP_CAP_LIMIT)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .frame_time     (frame.frame_time),
        .cmd            (cmd),
        .steps_run      (result.steps_run),
        .steps_dropped  (result.steps_dropped),
        .blend_fraction (result.blend_fraction),
        .total_steps    (result.total_steps),
        .total_dropped  (result.total_dropped),
        .frame_number   (result.frame_number),
        .simulated_time (result.simulated_time)
    );

    `FTSA_ASSERT_NEXT(a_busy_after_request, frame.valid && frame.ready, !frame.ready)
    `FTSA_ASSERT_IMPL(a_run_capped, result.valid, result.steps_run <= MAX_STEPS_W'(STEP_CAP_LIMIT))
    `FTSA_ASSERT_IMPL(a_frame_counted, $rose(result.valid), result.frame_number != $past(result.frame_number))

endmodule
